### sv/swmed_pkg.sv
// Shared types and constants for the six-lane running median filter.
package swmed_pkg;

  localparam int SAMPLE_W  = 32;  // Q16.16 sample width
  localparam int NUM_LANES = 6;   // lanes carried on the stream words
  localparam int CFG_W     = 6;   // window length register width
  localparam int BIT_CNT_W = $clog2(SAMPLE_W);

  // action codes carried in tuser
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_HOLD
  } swmed_state_e;

endpackage

### sv/sliding_window_median_six_channel_unit.sv
// Running median filter over up to six lanes, bit-serial radix selection.
// A filter word is taken in the idle state; the select state then walks the sample bits,
//   one per cycle, MSB first, and the hold state loads the output register once it is free.
// Words are taken only when idle, after the last result is loaded; a clear gives no result.
// The select loop walks the 32 bits of the sample width; window length does not matter.
// Reset: window empty, window length 1, output empty; history needs no clearing.
module sliding_window_median_six_channel_unit
  import swmed_pkg::*;
#(
  parameter int WINDOW_MAX = 32,
  parameter int CHANNELS   = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // sample_0 .. sample_5, 32 bits each, sample_0 lowest
  input  logic [NUM_LANES*SAMPLE_W-1:0] s_axis_tdata,
  // action
  input  logic [0:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // median_0 .. median_5, 32 bits each, median_0 lowest
  output logic [NUM_LANES*SAMPLE_W-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int KW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX / 2 + 1) : 1;
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  swmed_state_e state_q, state_d;

  logic [CFG_W-1:0]     len_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic [BIT_CNT_W-1:0] bit_q, bit_d;

  // history as a shift line per lane: entry 0 is the newest sample
  logic [SAMPLE_W-1:0]   hist_q [CHANNELS][WINDOW_MAX];
  logic [WINDOW_MAX-1:0] cand_q [CHANNELS];
  logic [WINDOW_MAX-1:0] cand_d [CHANNELS];
  logic [KW-1:0]         k_q    [CHANNELS];
  logic [KW-1:0]         k_d    [CHANNELS];
  logic [SAMPLE_W-1:0]   med_q  [CHANNELS];
  logic [SAMPLE_W-1:0]   med_d  [CHANNELS];
  logic [SAMPLE_W-1:0]   samp   [CHANNELS];

  logic [NUM_LANES*SAMPLE_W-1:0] out_q, med_pack;
  logic                          out_valid_q;

  logic acc, acc_filter, acc_clear, step, load_out, flip;
  logic [CW-1:0] eff_len, fill_new;

  genvar g;
  generate
    for (g = 0; g < NUM_LANES; g++) begin : g_lane
      if (g < CHANNELS) begin : g_used
        assign samp[g] = s_axis_tdata[g*SAMPLE_W +: SAMPLE_W];
        assign med_pack[g*SAMPLE_W +: SAMPLE_W] = med_q[g];
      end else begin : g_unused
        assign med_pack[g*SAMPLE_W +: SAMPLE_W] = '0;
      end
    end
  endgenerate

  assign acc        = s_axis_tvalid && s_axis_tready;
  assign acc_filter = acc && (s_axis_tuser[0] == ACT_FILTER);
  assign acc_clear  = acc && (s_axis_tuser[0] == ACT_CLEAR);
  assign cfg_ready_o = 1'b1;

  // effective window length: zero reads as one, saturates at WINDOW_MAX
  always_comb begin
    logic [LW-1:0] len_ext;
    logic [CW:0]   fill_inc;
    len_ext = LW'(len_q);
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > LW'(WINDOW_MAX)) begin
      eff_len = CW'(WINDOW_MAX);
    end else begin
      eff_len = CW'(len_ext);
    end
    fill_inc = {1'b0, fill_q} + (CW+1)'(1);
    if (fill_inc > {1'b0, eff_len}) begin
      fill_new = eff_len;
    end else begin
      fill_new = fill_inc[CW-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc_filter) state_d = ST_SEL;
      end
      ST_SEL: begin
        if (bit_q == BIT_CNT_W'(SAMPLE_W - 1)) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    step          = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SEL:  step = 1'b1;
      ST_HOLD: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // the first bit is the sign: inverting it gives the order of unsigned keys
  assign flip = (bit_q == '0);

  // one radix select step per lane: keep candidates matching the median key so far
  always_comb begin
    logic [CW-1:0] cnt0;
    logic          take;
    logic          kb;
    fill_d = fill_q;
    bit_d  = bit_q;
    if (acc_clear) fill_d = '0;
    if (acc_filter) begin
      fill_d = fill_new;
      bit_d  = '0;
    end else if (step) begin
      bit_d = bit_q + BIT_CNT_W'(1);
    end
    for (int c = 0; c < CHANNELS; c++) begin
      cand_d[c] = cand_q[c];
      k_d[c]    = k_q[c];
      med_d[c]  = med_q[c];
      cnt0 = '0;
      take = 1'b0;
      kb   = 1'b0;
      if (acc_filter) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
          cand_d[c][i] = (CW'(i) < fill_new);
        end
        k_d[c] = KW'(fill_new >> 1);
      end else if (step) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
          kb = hist_q[c][i][SAMPLE_W-1] ^ flip;
          if (cand_q[c][i] && !kb) cnt0 = cnt0 + CW'(1);
        end
        take = (CW'(k_q[c]) >= cnt0);
        for (int i = 0; i < WINDOW_MAX; i++) begin
          kb = hist_q[c][i][SAMPLE_W-1] ^ flip;
          cand_d[c][i] = cand_q[c][i] && (kb == take);
        end
        if (take) k_d[c] = KW'(CW'(k_q[c]) - cnt0);
        med_d[c] = {med_q[c][SAMPLE_W-2:0], take ^ flip};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= CFG_W'(1);
      fill_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bit_q   <= bit_d;
      if (cfg_valid_i && cfg_ready_o) len_q <= cfg_data_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload: shift in on a filter word, rotate one bit per select cycle
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      cand_q[c] <= cand_d[c];
      k_q[c]    <= k_d[c];
      med_q[c]  <= med_d[c];
      if (acc_filter) begin
        hist_q[c][0] <= samp[c];
        for (int i = 1; i < WINDOW_MAX; i++) begin
          hist_q[c][i] <= hist_q[c][i-1];
        end
      end else if (step) begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
          hist_q[c][i] <= {hist_q[c][i][SAMPLE_W-2:0], hist_q[c][i][SAMPLE_W-1]};
        end
      end
    end
    if (load_out) out_q <= med_pack;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // a filter word always finishes its select run and reaches the hold state
  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_filter |-> ##(SAMPLE_W + 1) (state_q == ST_HOLD))
    else $error("select run length wrong");

  // a result only appears out of the done state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_HOLD))
    else $error("result without finished run");

  generate
    for (g = 0; g < CHANNELS; g++) begin : g_chk
      // the wanted rank always lies inside the remaining candidates
      a_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
        (state_q == ST_SEL) |-> (32'(k_q[g]) < 32'($countones(cand_q[g]))))
        else $error("median rank outside candidate set");
    end
  endgenerate

endmodule

### tb/sliding_window_median_six_channel_unit_tb.sv
// Testbench for the six-lane running median filter: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module sliding_window_median_six_channel_unit_tb
  import swmed_pkg::*;
();

  localparam int WIN_MAX  = 32;
  localparam int HOLD_LEN = 400;   // long receiver hold-off, in cycles
  localparam int SETTLE   = 40;    // cycles to let the block go quiet

  typedef logic signed [SAMPLE_W-1:0]         sample_t;
  typedef logic [NUM_LANES*SAMPLE_W-1:0]      lane_word_t;
  typedef enum logic {ROW_WORD, ROW_CFG}      row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic             act;
    lane_word_t       data;
    bit               typed;   // expected medians equal the samples
    logic [CFG_W-1:0] cfg;
  } dir_row_t;

  typedef struct {
    int unsigned      win;
    int unsigned      send_idle;
    int unsigned      recv_stall;
    int unsigned      items;
  } phase_t;

  localparam sample_t S_MAX = 32'sh7fff_ffff;
  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t Q_ONE = 32'sh0001_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  lane_word_t s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = ACT_FILTER;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  lane_word_t m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;

  // filter model state
  sample_t          hist [NUM_LANES][WIN_MAX];
  int unsigned      held;
  int unsigned      oldest;
  logic [CFG_W-1:0] win_len;

  lane_word_t  median_q[$];
  int unsigned errors;
  int unsigned results_seen;
  int unsigned send_idle;
  int unsigned recv_stall;
  bit          hold_go;
  bit          hold_taken;
  int unsigned hold_cnt;

  sliding_window_median_six_channel_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  function automatic lane_word_t lanes(input sample_t a, b, c, d, e, f);
    return {f, e, d, c, b, a};
  endfunction

  function automatic void clear_windows();
    held   = 0;
    oldest = 0;
  endfunction

  // queue one expected result word behind the others
  function automatic void expect_word(input lane_word_t w);
    median_q = {median_q, w};
  endfunction

  // Store one sample set, trim to the window length, rank each lane, take index count/2.
  function automatic lane_word_t filter_word(input lane_word_t samples);
    int unsigned len;
    int unsigned cnt;
    int unsigned slot;
    int          j;
    sample_t     ranked [WIN_MAX];
    sample_t     v;
    lane_word_t  med;
    len = win_len;
    if (len < 1) len = 1;
    if (len > WIN_MAX) len = WIN_MAX;
    slot = (oldest + held) % WIN_MAX;
    for (int ch = 0; ch < NUM_LANES; ch++) hist[ch][slot] = samples[ch*SAMPLE_W +: SAMPLE_W];
    cnt = held + 1;
    if (cnt > len) begin
      oldest = (oldest + cnt - len) % WIN_MAX;
      cnt = len;
    end
    held = cnt;
    med = '0;
    for (int ch = 0; ch < NUM_LANES; ch++) begin
      for (int i = 0; i < cnt; i++) ranked[i] = hist[ch][(oldest + i) % WIN_MAX];
      for (int i = 1; i < cnt; i++) begin
        v = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] > v) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = v;
      end
      med[ch*SAMPLE_W +: SAMPLE_W] = ranked[cnt/2];
    end
    return med;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return sample_t'($urandom_range(8)) - 4;   // narrow spread, many ties
      2: begin
        case ($urandom_range(3))
          0: return S_MAX;
          1: return S_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return sample_t'($urandom_range(200 * 65536)) - 100 * Q_ONE;
    endcase
  endfunction

  function automatic dir_row_t word_row(input logic act, input lane_word_t d, input bit typed);
    dir_row_t r;
    r.kind  = ROW_WORD;
    r.act   = act;
    r.data  = d;
    r.typed = typed;
    r.cfg   = '0;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_W-1:0] v);
    dir_row_t r;
    r.kind  = ROW_CFG;
    r.act   = ACT_FILTER;
    r.data  = '0;
    r.typed = 1'b0;
    r.cfg   = v;
    return r;
  endfunction

  function automatic phase_t phase_row(input int unsigned win, idle, stall, items);
    phase_t ph;
    ph.win        = win;
    ph.send_idle  = idle;
    ph.recv_stall = stall;
    ph.items      = items;
    return ph;
  endfunction

  task automatic send_word(input logic act, input lane_word_t d, input bit typed);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_CLEAR) begin
      clear_windows();
    end else if (typed) begin
      // window of one sample: each median is the sample itself
      void'(filter_word(d));
      expect_word(d);
    end else begin
      expect_word(filter_word(d));
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (median_q.size() != 0);
  endtask

  // only while idle: waits until all results are in, then lets the block settle
  task automatic write_window(input logic [CFG_W-1:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    win_len = v;
  endtask

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_cnt      <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    lane_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (median_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        want = median_q.pop_front();
        for (int ch = 0; ch < NUM_LANES; ch++) begin
          if (m_axis_tdata[ch*SAMPLE_W +: SAMPLE_W] !== want[ch*SAMPLE_W +: SAMPLE_W])
            report_mismatch($sformatf("result %0d median_%0d: got %h, want %h", results_seen,
                                      ch, m_axis_tdata[ch*SAMPLE_W +: SAMPLE_W],
                                      want[ch*SAMPLE_W +: SAMPLE_W]));
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dir_row_t   dir_rows[$];
    phase_t     phases[$];
    lane_word_t d;
    logic       act;
    int unsigned n;

    errors = 0;
    results_seen = 0;
    send_idle = 0;
    recv_stall = 0;
    hold_go = 1'b0;
    hold_taken = 1'b0;
    hold_cnt = 0;
    win_len = 1;
    clear_windows();

    // window length 1 after reset: extremes pass straight through
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(S_MAX, S_MIN, 0, -1, Q_ONE, -Q_ONE), 1)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(S_MIN, S_MAX, -1, 0, -Q_ONE, Q_ONE), 1)};
    dir_rows = {dir_rows, word_row(ACT_CLEAR, '1, 0)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(5, -5, 3 * Q_ONE, -7, S_MAX, 1), 1)};
    // zero length acts as one
    dir_rows = {dir_rows, cfg_row(0)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(-2, 2, S_MIN, S_MAX, 0, Q_ONE), 1)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(9, -9, 1, -1, S_MIN, 0), 1)};
    // oversize length saturates at the ring depth
    dir_rows = {dir_rows, cfg_row(63)};
    for (int i = 0; i < 7; i++)
      dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(i * Q_ONE, -i, S_MAX - i, S_MIN + i,
                                     (i % 2) ? S_MAX : S_MIN, i % 3), 0)};
    // shortened below the fill: oldest entries drop on the next word
    dir_rows = {dir_rows, cfg_row(3)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(-Q_ONE, 100, 0, 0, -1, 2), 0)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(Q_ONE, -100, -1, 1, 0, 2), 0)};
    // clear keeps the length; then a single entry, then two (upper middle)
    dir_rows = {dir_rows, word_row(ACT_CLEAR, '0, 0)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(17, -17, S_MAX, S_MIN, Q_ONE, 0), 1)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(18, -18, S_MIN, S_MAX, -Q_ONE, 0), 0)};
    dir_rows = {dir_rows, cfg_row(32)};
    dir_rows = {dir_rows, word_row(ACT_FILTER, lanes(0, 0, 0, -1, -1, S_MIN), 0)};

    phases = {phases, phase_row(32, 0, 0, 140)};
    phases = {phases, phase_row(5, 46, 0, 120)};
    phases = {phases, phase_row(17, 0, 46, 130)};
    phases = {phases, phase_row(63, 28, 28, 130)};
    phases = {phases, phase_row(2, 28, 28, 80)};
    phases = {phases, phase_row(0, 0, 0, 50)};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_window(dir_rows[r].cfg);
      else send_word(dir_rows[r].act, dir_rows[r].data, dir_rows[r].typed);
    end

    foreach (phases[p]) begin
      write_window(phases[p].win[CFG_W-1:0]);
      send_idle  = phases[p].send_idle;
      recv_stall = phases[p].recv_stall;
      // receiver goes dark while words keep coming, so the input backs up
      if (p == 0) hold_go = 1'b1;
      for (int i = 0; i < phases[p].items; i++) begin
        if (p == 1 && i == phases[p].items / 2) wait_drained();
        act = ($urandom_range(99) < 4) ? ACT_CLEAR : ACT_FILTER;
        for (int ch = 0; ch < NUM_LANES; ch++) d[ch*SAMPLE_W +: SAMPLE_W] = rand_sample();
        send_word(act, d, 0);
      end
    end

    s_axis_tvalid <= 1'b0;
    n = 0;
    while (median_q.size() != 0 && n < 20000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (median_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", median_q.size()));

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/swmed_pkg.sv
sv/sliding_window_median_six_channel_unit.sv
tb/sliding_window_median_six_channel_unit_tb.sv
